// ----- design/lric_pkg.sv -----
// Shared types and constants for the LiDAR range and intensity compensation unit.
package lric_pkg;

  localparam int COEF_W      = 24;
  localparam int INT_W       = 8;
  localparam int RANGE_OUT_W = 20;
  localparam int CFG_IDX_W   = 2;

  localparam logic [INT_W-1:0] INT_MAX = 8'd255;

  localparam logic signed [COEF_W-1:0] COEF_SQUARE_RST = -24'sd5642;
  localparam logic signed [COEF_W-1:0] COEF_LINEAR_RST = 24'sd141764;
  localparam logic signed [COEF_W-1:0] COEF_OFFSET_RST = 24'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_SQUARE = 2'd0,
    CFG_COEF_LINEAR = 2'd1,
    CFG_COEF_OFFSET = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [INT_W-1:0]       comp_intensity;
    logic                   point_valid;
    logic [RANGE_OUT_W-1:0] range_q10;
  } res_t;

endpackage

// ----- design/lric_sumsq.sv -----
// Three-stage front end: coordinate magnitudes, squares and their sum.
module lric_sumsq #(
  parameter int CW = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_v,
  input  logic signed [CW-1:0]          pos_x,
  input  logic signed [CW-1:0]          pos_y,
  input  logic signed [CW-1:0]          pos_z,
  input  logic [lric_pkg::INT_W-1:0]    raw,
  output logic                          sum_v,
  output logic [2*CW-1:0]               sum,
  output logic [lric_pkg::INT_W-1:0]    sum_raw
);
  import lric_pkg::*;

  localparam int SQ_W = 2 * CW;

  logic [CW-1:0]    ax_nxt, ay_nxt, az_nxt;
  logic [CW-1:0]    ax_r, ay_r, az_r;
  logic             s1_v_r, s2_v_r, s3_v_r;
  logic [INT_W-1:0] s1_raw_r, s2_raw_r, s3_raw_r;
  logic [SQ_W-1:0]  sqx_r, sqy_r, sqz_r, sum_r;

  // The most negative coordinate still fits as an unsigned magnitude of CW bits.
  assign ax_nxt = pos_x[CW-1] ? (~pos_x + 1'b1) : pos_x;
  assign ay_nxt = pos_y[CW-1] ? (~pos_y + 1'b1) : pos_y;
  assign az_nxt = pos_z[CW-1] ? (~pos_z + 1'b1) : pos_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r     <= ax_nxt;
      ay_r     <= ay_nxt;
      az_r     <= az_nxt;
      s1_raw_r <= raw;
      sqx_r    <= ax_r * ax_r;
      sqy_r    <= ay_r * ay_r;
      sqz_r    <= az_r * az_r;
      s2_raw_r <= s1_raw_r;
      // Three squares of magnitudes up to 2^(CW-1) stay below 2^(2*CW).
      sum_r    <= sqx_r + sqy_r + sqz_r;
      s3_raw_r <= s2_raw_r;
    end
  end

  assign sum_v   = s3_v_r;
  assign sum     = sum_r;
  assign sum_raw = s3_raw_r;

endmodule

// ----- design/lric_isqrt.sv -----
// Pipelined integer square root, one root bit resolved per register stage.
module lric_isqrt #(
  parameter int CW = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_v,
  input  logic [2*CW-1:0]            radicand,
  input  logic [lric_pkg::INT_W-1:0] in_raw,
  output logic                       root_v,
  output logic [CW-1:0]              root,
  output logic [lric_pkg::INT_W-1:0] root_raw
);
  import lric_pkg::*;

  localparam int SQ_W = 2 * CW;

  logic [SQ_W-1:0]  rem_s  [0:CW];
  logic [CW-1:0]    root_s [0:CW];
  logic             v_s    [0:CW];
  logic [INT_W-1:0] raw_s  [0:CW];

  assign rem_s[0]  = radicand;
  assign root_s[0] = '0;
  assign v_s[0]    = in_v;
  assign raw_s[0]  = in_raw;

  for (genvar k = 0; k < CW; k++) begin : g_step
    localparam int B = CW - 1 - k;

    logic [SQ_W-1:0]  trial;
    logic             fits;
    logic [SQ_W-1:0]  rem_nxt, rem_r;
    logic [CW-1:0]    root_nxt, root_r;
    logic             v_r;
    logic [INT_W-1:0] raw_r;

    // Setting bit B of the root adds (2*root + 2^B) * 2^B to its square.
    assign trial    = (SQ_W'(root_s[k]) << (B + 1)) | (SQ_W'(1) << (2 * B));
    assign fits     = rem_s[k] >= trial;
    assign rem_nxt  = fits ? (rem_s[k] - trial) : rem_s[k];
    assign root_nxt = fits ? (root_s[k] | (CW'(1) << B)) : root_s[k];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        raw_r  <= raw_s[k];
      end
    end

    assign rem_s[k+1]  = rem_r;
    assign root_s[k+1] = root_r;
    assign v_s[k+1]    = v_r;
    assign raw_s[k+1]  = raw_r;
  end

  assign root_v   = v_s[CW];
  assign root     = root_s[CW];
  assign root_raw = raw_s[CW];

endmodule

// ----- design/lric_poly.sv -----
// Six-stage correction: quadratic in range, subtraction, rounding and clamping.
module lric_poly #(
  parameter int CW  = 20,
  parameter int CFB = 10,
  parameter int EFB = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               in_v,
  input  logic [CW-1:0]                      rng,
  input  logic [lric_pkg::INT_W-1:0]         raw,
  input  logic signed [lric_pkg::COEF_W-1:0] coef_sq,
  input  logic signed [lric_pkg::COEF_W-1:0] coef_lin,
  input  logic signed [lric_pkg::COEF_W-1:0] coef_off,
  output logic                               res_v,
  output lric_pkg::res_t                     res
);
  import lric_pkg::*;

  localparam int AR_W = COEF_W + CW + 1;
  localparam int T_W  = ((AR_W > COEF_W + CFB) ? AR_W : COEF_W + CFB) + 1;
  localparam int T_LO = T_W / 2;
  localparam int T_HI = T_W - T_LO;
  localparam int P_W  = ((CW + 1 + T_W > COEF_W + 2 * CFB) ?
                         CW + 1 + T_W : COEF_W + 2 * CFB) + 1;
  localparam int S    = EFB + 2 * CFB;
  localparam int V_W  = ((P_W > INT_W + S + 1) ? P_W : INT_W + S + 1) + 1;

  typedef struct packed {
    logic                   zero_rng;
    logic [INT_W-1:0]       raw;
    logic [RANGE_OUT_W-1:0] rng_out;
  } side_t;

  side_t                    a_side_nxt;
  side_t                    a_side_r, b_side_r, c_side_r, d_side_r, e_side_r;
  logic                     a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r;
  logic [CW-1:0]            a_rng_r, b_rng_r;
  logic signed [AR_W-1:0]   a_ar_nxt, a_ar_r;
  logic signed [T_W-1:0]    b_t_nxt, b_t_r;
  logic [CW+T_LO-1:0]       c_plo_nxt, c_plo_r;
  logic signed [CW+T_HI:0]  c_phi_nxt, c_phi_r;
  logic signed [P_W-1:0]    d_p_nxt, d_p_r;
  logic signed [V_W-1:0]    e_rnd_nxt, e_rnd_r;
  res_t                     f_res_nxt, f_res_r;

  assign a_side_nxt.zero_rng = (rng == '0);
  assign a_side_nxt.raw      = raw;
  assign a_side_nxt.rng_out  = RANGE_OUT_W'(rng);

  // The polynomial is evaluated as R * (a*R + b*2^f) + c*2^(2f), all over 2^S.
  assign a_ar_nxt  = coef_sq * $signed({1'b0, rng});
  assign b_t_nxt   = T_W'(a_ar_r) + (T_W'(coef_lin) <<< CFB);
  assign c_plo_nxt = b_rng_r * b_t_r[T_LO-1:0];
  assign c_phi_nxt = $signed({1'b0, b_rng_r}) * $signed(b_t_r[T_W-1:T_LO]);
  assign d_p_nxt   = (P_W'(c_phi_r) <<< T_LO) + P_W'(c_plo_r)
                   + (P_W'(coef_off) <<< (2 * CFB));
  // The raw value shifted up has clear low bits, so the rounding half is ORed in.
  assign e_rnd_nxt = ((V_W'(d_side_r.raw) << S) | (V_W'(1) << (S - 1))) - V_W'(d_p_r);

  always_comb begin
    f_res_nxt.point_valid = !e_side_r.zero_rng;
    f_res_nxt.range_q10   = e_side_r.rng_out;
    priority if (e_side_r.zero_rng) begin
      f_res_nxt.comp_intensity = e_side_r.raw;
    end else if (e_rnd_r[V_W-1]) begin
      f_res_nxt.comp_intensity = '0;
    end else if (|e_rnd_r[V_W-2:S+INT_W]) begin
      f_res_nxt.comp_intensity = INT_MAX;
    end else begin
      f_res_nxt.comp_intensity = e_rnd_r[S+INT_W-1:S];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side_r <= a_side_nxt;
      a_rng_r  <= rng;
      a_ar_r   <= a_ar_nxt;
      b_side_r <= a_side_r;
      b_rng_r  <= a_rng_r;
      b_t_r    <= b_t_nxt;
      c_side_r <= b_side_r;
      c_plo_r  <= c_plo_nxt;
      c_phi_r  <= c_phi_nxt;
      d_side_r <= c_side_r;
      d_p_r    <= d_p_nxt;
      e_side_r <= d_side_r;
      e_rnd_r  <= e_rnd_nxt;
      f_res_r  <= f_res_nxt;
    end
  end

  assign res_v = f_v_r;
  assign res   = f_res_r;

endmodule

// ----- design/lric_outbuf.sv -----
// Output register with a skid stage, so the pipeline halts only once a beat is parked.
module lric_outbuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_v,
  input  lric_pkg::res_t res,
  input  logic           out_stall,
  output logic           out_v,
  output lric_pkg::res_t out_res,
  output logic           skid_full
);
  import lric_pkg::*;

  logic out_v_r, out_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;
  logic out_free;
  logic incoming;

  assign out_free = !out_v_r || !out_stall;
  // The pipeline is frozen while the skid stage holds a beat.
  assign incoming = res_v && !skid_v_r;

  always_comb begin
    out_v_nxt    = out_v_r;
    out_res_nxt  = out_res_r;
    skid_v_nxt   = skid_v_r;
    skid_res_nxt = skid_res_r;
    priority if (out_free && skid_v_r) begin
      out_v_nxt   = 1'b1;
      out_res_nxt = skid_res_r;
      skid_v_nxt  = 1'b0;
    end else if (out_free) begin
      out_v_nxt   = incoming;
      out_res_nxt = res;
    end else if (incoming) begin
      skid_v_nxt   = 1'b1;
      skid_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_v     = out_v_r;
  assign out_res   = out_res_r;
  assign skid_full = skid_v_r;

endmodule

// ----- design/lidar_range_intensity_compensation_unit.sv -----
// Top level of the LiDAR range and intensity compensation unit.
// One point is taken per clock cycle while in_stall is low. A front end forms the sum of
// squares, the square root resolves one bit of range per pipeline stage (COORD_WIDTH stages),
// six stages evaluate the range quadratic and round and clamp the intensity, and an output
// register follows. A stalled output parks one further beat in a skid stage; only then does
// in_stall rise, and the whole pipeline holds until the skid stage drains. The coefficient
// registers are read by the pipeline directly and are to be written only while no point is
// in flight.
module lidar_range_intensity_compensation_unit #(
  parameter int COORD_WIDTH     = 20,
  parameter int COORD_FRAC_BITS = 10,
  parameter int COEF_FRAC_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COORD_WIDTH-1:0]          in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]          in_pos_y,
  input  logic signed [COORD_WIDTH-1:0]          in_pos_z,
  input  logic [lric_pkg::INT_W-1:0]             in_raw_intensity,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [lric_pkg::INT_W-1:0]             out_comp_intensity,
  output logic                                   out_point_valid,
  output logic [lric_pkg::RANGE_OUT_W-1:0]       out_range_q10,
  input  logic                                   cfg_wr_en,
  input  logic [lric_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lric_pkg::COEF_W-1:0]            cfg_data
);
  import lric_pkg::*;

  logic signed [COEF_W-1:0] coef_sq_r, coef_lin_r, coef_off_r;
  logic                     adv;
  logic                     sum_v;
  logic [2*COORD_WIDTH-1:0] sum;
  logic [INT_W-1:0]         sum_raw;
  logic                     root_v;
  logic [COORD_WIDTH-1:0]   root;
  logic [INT_W-1:0]         root_raw;
  logic                     res_v;
  res_t                     res;
  res_t                     out_res;
  logic                     skid_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_sq_r  <= COEF_SQUARE_RST;
      coef_lin_r <= COEF_LINEAR_RST;
      coef_off_r <= COEF_OFFSET_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_COEF_SQUARE: coef_sq_r  <= $signed(cfg_data);
        CFG_COEF_LINEAR: coef_lin_r <= $signed(cfg_data);
        CFG_COEF_OFFSET: coef_off_r <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  assign adv      = !skid_full;
  assign in_stall = skid_full;

  lric_sumsq #(
    .CW (COORD_WIDTH)
  ) u_sumsq (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (in_valid),
    .pos_x   (in_pos_x),
    .pos_y   (in_pos_y),
    .pos_z   (in_pos_z),
    .raw     (in_raw_intensity),
    .sum_v   (sum_v),
    .sum     (sum),
    .sum_raw (sum_raw)
  );

  lric_isqrt #(
    .CW (COORD_WIDTH)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (sum_v),
    .radicand (sum),
    .in_raw   (sum_raw),
    .root_v   (root_v),
    .root     (root),
    .root_raw (root_raw)
  );

  lric_poly #(
    .CW  (COORD_WIDTH),
    .CFB (COORD_FRAC_BITS),
    .EFB (COEF_FRAC_BITS)
  ) u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (root_v),
    .rng      (root),
    .raw      (root_raw),
    .coef_sq  (coef_sq_r),
    .coef_lin (coef_lin_r),
    .coef_off (coef_off_r),
    .res_v    (res_v),
    .res      (res)
  );

  lric_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_v     (res_v),
    .res       (res),
    .out_stall (out_stall),
    .out_v     (out_valid),
    .out_res   (out_res),
    .skid_full (skid_full)
  );

  assign out_comp_intensity = out_res.comp_intensity;
  assign out_point_valid    = out_res.point_valid;
  assign out_range_q10      = out_res.range_q10;

  // A parked beat always sits behind a beat on the output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full |-> out_valid)
    else $error("skid stage holds a beat while the output is empty");

  // The skid stage fills only when the output beat was held back.
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full) |-> $past(out_valid && out_stall))
    else $error("skid stage filled without a stalled output beat");

  // While the pipeline is frozen, its last stage neither gains nor loses a beat.
  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(res_v))
    else $error("pipeline output changed while frozen");

  // A point is flagged invalid only when its range is zero.
  a_invalid_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_point_valid) |-> (out_range_q10 == '0))
    else $error("invalid point with nonzero range");

endmodule
